>>> rtl/snb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// snb_pkg
// Shared constants and types for the stereo notch biquad.
// ----------------------------------------------------------------------------
package snb_pkg;

  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;

  localparam int ZERO_COEF_W  = 16;
  localparam int POLE_ONE_W   = 16;
  localparam int POLE_TWO_W   = 15;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_COEF     = 2'd0,
    REG_POLE_COEF_ONE = 2'd1,
    REG_POLE_COEF_TWO = 2'd2
  } cfg_reg_t;

endpackage
`default_nettype wire

>>> rtl/stereo_notch_biquad_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_notch_biquad_top
// Second-order IIR notch filter, direct form I, for a stereo sample stream.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in_      slave      tvalid/tready/tlast  tdata: left, right; tlast: block_last
// out_     master     tvalid/tready/tlast  tdata: left, right; tlast: block_end
// cfg_     slave      valid/ready          addr: register index, data: value
//
// One sample pair per clock cycle is sustained while the output is not stalled;
// the feedback path from the output history through the three parallel
// multipliers and the sum of each channel is combinational, which allows that.
// A pair is held in an input register, filtered and written to the output
// register, which drives out_tvalid.
// Reset (synchronous, rst_n low) clears coefficients, history and valids.
// A stalled output keeps one further pair waiting in the input register.
// ----------------------------------------------------------------------------
module stereo_notch_biquad_top #(
  parameter int SAMPLE_BITS    = snb_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = snb_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // bits up: left_sample, right_sample, zero padding
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  input  wire logic                                  in_tlast,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // bits up: left_result, right_result, zero padding
  output logic      [((2*SAMPLE_BITS+7)/8)*8-1:0]    out_tdata,
  output logic                                       out_tlast,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [snb_pkg::CFG_IDX_W-1:0]         cfg_addr,
  input  wire logic [snb_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import snb_pkg::*;

  localparam int S      = SAMPLE_BITS;
  localparam int F      = COEF_FRAC_BITS;
  localparam int TD_W   = ((2*S+7)/8)*8;
  localparam int PAD_W  = TD_W - 2*S;
  localparam int P1_W   = S + ZERO_COEF_W;
  localparam int P2_W   = S + POLE_ONE_W;
  localparam int P3_W   = S + POLE_TWO_W;
  localparam int XS_W   = S + F + 1;
  localparam int MAXW_A = (P1_W > P2_W) ? P1_W : P2_W;
  localparam int MAXW_B = (MAXW_A > XS_W) ? MAXW_A : XS_W;
  localparam int ACC_W  = MAXW_B + 3;
  localparam int SH_W   = ACC_W - F;

  localparam logic signed [ACC_W-1:0] ROUND   = ACC_W'(1) <<< (F-1);
  localparam logic signed [SH_W-1:0]  SAT_MAX = {{(SH_W-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [SH_W-1:0]  SAT_MIN = ~SAT_MAX;

  logic signed [ZERO_COEF_W-1:0] zero_coef_r;
  logic signed [POLE_ONE_W-1:0]  pole_one_r;
  logic signed [POLE_TWO_W-1:0]  pole_two_r;

  logic                 s1_valid_r;
  logic signed [S-1:0]  s1_left_r;
  logic signed [S-1:0]  s1_right_r;
  logic                 s1_last_r;

  logic signed [S-1:0]  l_xin_r [0:1];
  logic signed [S-1:0]  l_yout_r [0:1];
  logic signed [S-1:0]  r_xin_r [0:1];
  logic signed [S-1:0]  r_yout_r [0:1];

  logic                 out_valid_r;
  logic signed [S-1:0]  out_left_r;
  logic signed [S-1:0]  out_right_r;
  logic                 out_last_r;

  logic                 advance;
  logic                 in_accept;
  logic signed [S-1:0]  y_left_nxt;
  logic signed [S-1:0]  y_right_nxt;

  function automatic logic signed [S-1:0] biquad_step(
    input logic signed [S-1:0]           x0,
    input logic signed [S-1:0]           x1,
    input logic signed [S-1:0]           x2,
    input logic signed [S-1:0]           y1,
    input logic signed [S-1:0]           y2,
    input logic signed [ZERO_COEF_W-1:0] b1,
    input logic signed [POLE_ONE_W-1:0]  a1,
    input logic signed [POLE_TWO_W-1:0]  a2
  );
    logic signed [P1_W-1:0]  p1;
    logic signed [P2_W-1:0]  p2;
    logic signed [P3_W-1:0]  p3;
    logic signed [ACC_W-1:0] xs0;
    logic signed [ACC_W-1:0] xs2;
    logic signed [ACC_W-1:0] acc;
    logic signed [SH_W-1:0]  sh;
    logic signed [S-1:0]     y;
    p1  = b1 * x1;
    p2  = a1 * y1;
    p3  = a2 * y2;
    xs0 = ACC_W'(x0) <<< F;
    xs2 = ACC_W'(x2) <<< F;
    acc = xs0 + xs2 + ACC_W'(p1) + ACC_W'(p2) + ACC_W'(p3) + ROUND;
    sh  = $signed(acc[ACC_W-1:F]);
    if (sh > SAT_MAX) begin
      y = SAT_MAX[S-1:0];
    end else if (sh < SAT_MIN) begin
      y = SAT_MIN[S-1:0];
    end else begin
      y = sh[S-1:0];
    end
    return y;
  endfunction

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    y_left_nxt  = biquad_step(s1_left_r, l_xin_r[0], l_xin_r[1], l_yout_r[0],
                              l_yout_r[1], zero_coef_r, pole_one_r, pole_two_r);
    y_right_nxt = biquad_step(s1_right_r, r_xin_r[0], r_xin_r[1], r_yout_r[0],
                              r_yout_r[1], zero_coef_r, pole_one_r, pole_two_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_coef_r <= '0;
      pole_one_r  <= '0;
      pole_two_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ZERO_COEF:     zero_coef_r <= $signed(cfg_data[ZERO_COEF_W-1:0]);
        REG_POLE_COEF_ONE: pole_one_r  <= $signed(cfg_data[POLE_ONE_W-1:0]);
        REG_POLE_COEF_TWO: pole_two_r  <= $signed(cfg_data[POLE_TWO_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_left_r  <= $signed(in_tdata[S-1:0]);
      s1_right_r <= $signed(in_tdata[2*S-1:S]);
      s1_last_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_xin_r[0]  <= '0;
      l_xin_r[1]  <= '0;
      l_yout_r[0] <= '0;
      l_yout_r[1] <= '0;
      r_xin_r[0]  <= '0;
      r_xin_r[1]  <= '0;
      r_yout_r[0] <= '0;
      r_yout_r[1] <= '0;
    end else if (advance) begin
      l_xin_r[0]  <= s1_left_r;
      l_xin_r[1]  <= l_xin_r[0];
      l_yout_r[0] <= y_left_nxt;
      l_yout_r[1] <= l_yout_r[0];
      r_xin_r[0]  <= s1_right_r;
      r_xin_r[1]  <= r_xin_r[0];
      r_yout_r[0] <= y_right_nxt;
      r_yout_r[1] <= r_yout_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_left_r  <= y_left_nxt;
      out_right_r <= y_right_nxt;
      out_last_r  <= s1_last_r;
    end
  end

  generate
    if (PAD_W > 0) begin : g_pad
      assign out_tdata = {{PAD_W{1'b0}}, out_right_r, out_left_r};
    end else begin : g_nopad
      assign out_tdata = {out_right_r, out_left_r};
    end
  endgenerate

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input refused with an empty input register");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("filtered pair lost on its way to the output register");

  a_history_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_left_r == l_yout_r[0]) && (out_right_r == r_yout_r[0]))
    else $error("output history differs from the delivered result");

  a_history_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(l_xin_r[0]) && $stable(r_yout_r[0]))
    else $error("history changed without a transaction moving forward");

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo notch biquad. A table of directed
// stimulus runs first, then randomised phases, each with its own set of
// coefficients. Every accepted sample pair is filtered by a bit-exact model
// of both channels held in this bench, and each output transaction is
// compared field by field with the oldest pending prediction. Both stream
// sides idle at random; one phase holds the output back for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  import snb_pkg::*;

  localparam int            SB        = SAMPLE_BITS_DEF;
  localparam int            CF        = COEF_FRAC_BITS_DEF;
  localparam int            TDW       = ((2*SB+7)/8)*8;
  localparam longint        S_MAX     = (longint'(1) <<< (SB-1)) - 1;
  localparam longint        S_MIN     = -S_MAX - 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int            RX_HOLD   = 300;
  localparam int            N_PHASES  = 8;
  localparam int            PHASE_LEN = 50;

  typedef enum logic {ROW_PAIR, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [SB-1:0]          a;
    logic [SB-1:0]          b;
    logic                   blk_last;
    logic                   typed;
    logic [SB-1:0]          el;
    logic [SB-1:0]          er;
  } stim_row_t;

  typedef struct packed {
    logic [SB-1:0] left;
    logic [SB-1:0] right;
    logic          blk_end;
  } pair_t;

  localparam int N_ROWS = 29;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [TDW-1:0]        in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [TDW-1:0]        out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic signed [ZERO_COEF_W-1:0] zero_coef_q;
  logic signed [POLE_ONE_W-1:0]  pole_one_q;
  logic signed [POLE_TWO_W-1:0]  pole_two_q;
  logic signed [SB-1:0]          past_x [2][2];
  logic signed [SB-1:0]          past_y [2][2];

  pair_t filtered_q [$];
  int    err_count;
  bit    rx_hold_req;

  stim_row_t stim_tab [N_ROWS] = '{
    '{ROW_PAIR, REG_ZERO_COEF,     16'h7FFF, 16'h8000, 1'b0, 1'b1, 16'h7FFF, 16'h8000},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h8000, 16'h7FFF, 1'b1, 1'b1, 16'h8000, 16'h7FFF},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h7FFF, 16'h8000, 1'b0, 1'b1, 16'h7FFF, 16'h8000},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h8000, 16'h7FFF, 1'b0, 1'b1, 16'h8000, 16'h7FFF},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h0000, 16'h0000, 1'b1, 1'b1, 16'h7FFF, 16'h8000},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h0000, 16'h0000, 1'b0, 1'b1, 16'h8000, 16'h7FFF},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0000, 16'h0000},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'h0000},
    '{ROW_CFG,  REG_ZERO_COEF,     16'h8000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_CFG,  REG_POLE_COEF_ONE, 16'h7FFF, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_CFG,  REG_POLE_COEF_TWO, 16'hC000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h0064, 16'hFF9C, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h7FFF, 16'h8000, 1'b1, 1'b0, 16'h0000, 16'h0000},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h0001, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000, 16'h0000},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h3039, 16'hCFC7, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_CFG,  REG_ZERO_COEF,     16'h7FFF, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_CFG,  REG_POLE_COEF_ONE, 16'h8000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_CFG,  REG_POLE_COEF_TWO, 16'h3FFF, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_CFG,  REG_UNUSED,        16'hFFFF, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h8000, 16'h8000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_PAIR, REG_ZERO_COEF,     16'hFFFF, 16'h0001, 1'b1, 1'b0, 16'h0000, 16'h0000},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_CFG,  REG_POLE_COEF_TWO, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_CFG,  REG_POLE_COEF_ONE, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h1234, 16'hEDCC, 1'b1, 1'b0, 16'h0000, 16'h0000},
    '{ROW_PAIR, REG_ZERO_COEF,     16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 16'h0000}
  };

  stereo_notch_biquad_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [SB-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0: begin
        return 16'h7FFF;
      end
      1: begin
        return 16'h8000;
      end
      2, 3: begin
        return SB'($urandom_range(0, 64) - 32);
      end
      default: begin
        return SB'($urandom);
      end
    endcase
  endfunction

  // One channel of the filter: exact sum, round half up, floor shift, saturate.
  function automatic logic [SB-1:0] notch_step(input int ch, input logic signed [SB-1:0] x0);
    longint acc;
    longint y;
    acc = longint'(x0) * (longint'(1) <<< CF)
        + longint'(zero_coef_q) * longint'(past_x[ch][0])
        + longint'(past_x[ch][1]) * (longint'(1) <<< CF)
        + longint'(pole_one_q) * longint'(past_y[ch][0])
        + longint'(pole_two_q) * longint'(past_y[ch][1])
        + (longint'(1) <<< (CF-1));
    y = acc >>> CF;
    if (y > S_MAX) begin
      y = S_MAX;
    end
    if (y < S_MIN) begin
      y = S_MIN;
    end
    past_x[ch][1] = past_x[ch][0];
    past_x[ch][0] = x0;
    past_y[ch][1] = past_y[ch][0];
    past_y[ch][0] = SB'(y);
    return SB'(y);
  endfunction

  task automatic flag_error(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic send_pair(input logic [SB-1:0] l, input logic [SB-1:0] r,
                           input logic bl, input logic typed,
                           input logic [SB-1:0] el, input logic [SB-1:0] er,
                           input int gap);
    pair_t want;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= TDW'($urandom);
      in_tlast  <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDW'({r, l});
    in_tlast  <= bl;
    do @(posedge clk); while (!in_tready);
    want.left    = notch_step(0, l);
    want.right   = notch_step(1, r);
    want.blk_end = bl;
    if (typed) begin
      want.left  = el;
      want.right = er;
    end
    filtered_q.push_back(want);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ZERO_COEF: begin
        zero_coef_q = val;
      end
      REG_POLE_COEF_ONE: begin
        pole_one_q = val;
      end
      REG_POLE_COEF_TWO: begin
        pole_two_q = val[POLE_TWO_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : drive
    int   i;
    int   ph;
    int   gap;
    int   c;
    int   rr;
    int   zc;
    logic cfg_open;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_valid   = 1'b0;
    cfg_addr    = '0;
    cfg_data    = '0;
    rst_n       = 1'b0;
    err_count   = 0;
    rx_hold_req = 1'b0;
    zero_coef_q = '0;
    pole_one_q  = '0;
    pole_two_q  = '0;
    for (i = 0; i < 2; i++) begin
      past_x[i][0] = '0;
      past_x[i][1] = '0;
      past_y[i][0] = '0;
      past_y[i][1] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_open = 1'b0;
    for (i = 0; i < N_ROWS; i++) begin
      if (stim_tab[i].kind == ROW_CFG) begin
        if (!cfg_open) begin
          drain_outputs();
        end
        write_reg(stim_tab[i].idx, stim_tab[i].a);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
        end
        cfg_open = 1'b0;
        send_pair(stim_tab[i].a, stim_tab[i].b, stim_tab[i].blk_last, stim_tab[i].typed,
                  stim_tab[i].el, stim_tab[i].er, pick_gap());
      end
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      drain_outputs();
      case (ph % 4)
        0, 3: begin
          // Stable notch: cosine and pole radius in Q14.
          c  = int'($urandom_range(0, 32768)) - 16384;
          rr = $urandom_range(13000, 16383);
          zc = -2 * c;
          if (zc > 32767) begin
            zc = 32767;
          end
          write_reg(REG_ZERO_COEF, 16'(zc));
          write_reg(REG_POLE_COEF_ONE, 16'((2 * c * rr) / 16384));
          write_reg(REG_POLE_COEF_TWO, 16'(-((rr * rr) / 16384)));
          if (ph % 4 == 3) begin
            write_reg(REG_UNUSED, 16'($urandom));
          end
        end
        1: begin
          write_reg(REG_ZERO_COEF, 16'($urandom));
          write_reg(REG_POLE_COEF_ONE, 16'($urandom));
          write_reg(REG_POLE_COEF_TWO, 16'($urandom));
        end
        default: begin
          write_reg(REG_ZERO_COEF, $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF);
          write_reg(REG_POLE_COEF_ONE, $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF);
          write_reg(REG_POLE_COEF_TWO, $urandom_range(0, 1) ? 16'h4000 : 16'h8000);
        end
      endcase
      cfg_valid <= 1'b0;
      if (ph == 3) begin
        rx_hold_req = 1'b1;
      end
      for (i = 0; i < PHASE_LEN; i++) begin
        if ((ph == 3 && i < 30) || ph == 5) begin
          gap = 0;
        end else begin
          gap = pick_gap();
        end
        send_pair(pick_sample(), pick_sample(), ($urandom_range(0, 7) == 0), 1'b0,
                  '0, '0, gap);
      end
    end

    in_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : sink
    int burst;
    int stall;
    int k;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
        out_tready <= 1'b1;
        for (k = 0; k < burst && !rx_hold_req; k++) begin
          @(posedge clk);
        end
        stall = pick_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : check_out
    pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (filtered_q.size() == 0) begin
        flag_error("output transaction with no prediction pending");
      end else begin
        want = filtered_q.pop_front();
        if (out_tdata[SB-1:0] !== want.left) begin
          flag_error($sformatf("left got %h want %h", out_tdata[SB-1:0], want.left));
        end
        if (out_tdata[2*SB-1:SB] !== want.right) begin
          flag_error($sformatf("right got %h want %h", out_tdata[2*SB-1:SB], want.right));
        end
        if (out_tlast !== want.blk_end) begin
          flag_error($sformatf("block end got %b want %b", out_tlast, want.blk_end));
        end
      end
    end
  end

endmodule
